@@ hdl/rhc_pkg.sv @@
// ---------------------------------------------------------------------------
// rhc_pkg - shared constants for the RGB to HSV converter
// Default widths, the saturation fraction width and the queue depth.
// ---------------------------------------------------------------------------
package rhc_pkg;

  // default component and hue widths
  localparam int COMPONENT_BITS_DEF = 8;
  localparam int HUE_BITS_DEF       = 16;

  // saturation is always a 16-bit fraction of full scale
  localparam int SAT_BITS = 16;

  // depth of the queue between front and back
  localparam int FIFO_DEPTH_DEF = 4;

endpackage

@@ hdl/rhc_front.sv @@
// ---------------------------------------------------------------------------
// rhc_front - pixel intake and classification
// Registers one pixel, finds max, min and range, picks the hue sector and
// forms the wrapped hue numerator for the back end dividers.
// ---------------------------------------------------------------------------
module rhc_front #(
  parameter int CB = rhc_pkg::COMPONENT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [CB-1:0] red,
  input  logic [CB-1:0] green,
  input  logic [CB-1:0] blue,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB-1:0] out_value,
  output logic [CB-1:0] out_range,
  output logic [CB+2:0] out_num,
  output logic          out_gray
);
  import rhc_pkg::*;

  logic          vld;
  logic [CB-1:0] top;
  logic [CB-1:0] bot;
  logic [CB-1:0] rng;
  logic signed [CB+3:0] r_s, g_s, b_s, rng_s, num_s;
  logic          load;

  // pick max and min, ties resolved as blue over green over red
  always_comb begin
    if (red > green) begin
      top = (red > blue) ? red : blue;
    end else begin
      top = (green > blue) ? green : blue;
    end
    if (red < green) begin
      bot = (red < blue) ? red : blue;
    end else begin
      bot = (green < blue) ? green : blue;
    end
    rng = top - bot;
  end

  // form the hue numerator over range and wrap it into [0, 6*range)
  always_comb begin
    r_s   = signed'({4'b0000, red});
    g_s   = signed'({4'b0000, green});
    b_s   = signed'({4'b0000, blue});
    rng_s = signed'({4'b0000, rng});
    priority if (red == top) begin
      num_s = g_s - b_s;
    end else if (green == top) begin
      num_s = (rng_s <<< 1) + (b_s - r_s);
    end else begin
      num_s = (rng_s <<< 2) + (r_s - g_s);
    end
    if (num_s < 0) begin
      num_s = num_s + (rng_s <<< 2) + (rng_s <<< 1);
    end
  end

  // hold while the queue is full, otherwise take the next transfer
  assign load = !vld || out_ready;
  assign full = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= top;
      out_range <= rng;
      out_num   <= num_s[CB+2:0];
      out_gray  <= (rng == '0) || (top == '0);
    end
  end

  assign out_valid = vld;

endmodule

@@ hdl/rhc_fifo.sv @@
// ---------------------------------------------------------------------------
// rhc_fifo - short decoupling queue
// Register-based queue between the classifier and the divider pipeline.
// ---------------------------------------------------------------------------
module rhc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rhc_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import rhc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // store the incoming transfer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

@@ hdl/rhc_back.sv @@
// ---------------------------------------------------------------------------
// rhc_back - pipelined hue and saturation dividers
// One restoring division step per stage for each divider, with an elastic
// valid/ready chain so a stalled output only holds the stages behind it.
// ---------------------------------------------------------------------------
module rhc_back #(
  parameter int CB = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HB = rhc_pkg::HUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CB-1:0]           in_value,
  input  logic [CB-1:0]           in_range,
  input  logic [CB+2:0]           in_num,
  input  logic                    in_gray,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [HB-1:0]           hue,
  output logic [rhc_pkg::SAT_BITS-1:0] saturation,
  output logic [CB-1:0]           value
);
  import rhc_pkg::*;

  localparam int SB   = SAT_BITS;
  localparam int NSTG = (HB > SB) ? HB : SB;

  // per-stage registers, stage 0 is the load stage
  logic          vld  [NSTG+1];
  logic          rdy  [NSTG+1];
  logic          gray [NSTG+1];
  logic [CB-1:0] val  [NSTG+1];
  logic [CB-1:0] srem [NSTG+1];
  logic [SB-1:0] squo [NSTG+1];
  logic [CB+2:0] hrem [NSTG+1];
  logic [HB-1:0] hquo [NSTG+1];
  logic [CB+2:0] hdiv [NSTG+1];

  logic [CB+SB-1:0] sat_dividend;

  // range * 65535 as a shift and subtract
  assign sat_dividend = {in_range, SB'(0)} - (CB+SB)'(in_range);

  // ready chain: a stage moves when empty or when its successor moves
  assign rdy[NSTG] = !vld[NSTG] || out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready = rdy[0];

  // load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      gray[0] <= in_gray;
      val[0]  <= in_value;
      srem[0] <= sat_dividend[CB+SB-1:SB];
      squo[0] <= sat_dividend[SB-1:0];
      hrem[0] <= in_num;
      hquo[0] <= '0;
      hdiv[0] <= (CB+3)'({in_range, 2'b00}) + (CB+3)'({in_range, 1'b0});
    end
  end

  // division stages
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic [CB-1:0] srem_n;
    logic [SB-1:0] squo_n;
    logic [CB+2:0] hrem_n;
    logic [HB-1:0] hquo_n;

    if (k <= SB) begin : g_sat
      logic [CB:0] st;
      always_comb begin
        st = {srem[k-1], squo[k-1][SB-1]};
        if (st >= {1'b0, val[k-1]}) begin
          srem_n = CB'(st - {1'b0, val[k-1]});
          squo_n = {squo[k-1][SB-2:0], 1'b1};
        end else begin
          srem_n = st[CB-1:0];
          squo_n = {squo[k-1][SB-2:0], 1'b0};
        end
      end
    end else begin : g_sat_hold
      assign srem_n = srem[k-1];
      assign squo_n = squo[k-1];
    end

    if (k <= HB) begin : g_hue
      logic [CB+3:0] ht;
      always_comb begin
        ht = {hrem[k-1], 1'b0};
        if (ht >= {1'b0, hdiv[k-1]}) begin
          hrem_n = (CB+3)'(ht - {1'b0, hdiv[k-1]});
          hquo_n = {hquo[k-1][HB-2:0], 1'b1};
        end else begin
          hrem_n = ht[CB+2:0];
          hquo_n = {hquo[k-1][HB-2:0], 1'b0};
        end
      end
    end else begin : g_hue_hold
      assign hrem_n = hrem[k-1];
      assign hquo_n = hquo[k-1];
    end

    // advance one step when this stage may take a transfer
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        gray[k] <= gray[k-1];
        val[k]  <= val[k-1];
        srem[k] <= srem_n;
        squo[k] <= squo_n;
        hrem[k] <= hrem_n;
        hquo[k] <= hquo_n;
        hdiv[k] <= hdiv[k-1];
      end
    end
  end

  // drop hue and saturation for gray pixels
  assign out_valid  = vld[NSTG];
  assign hue        = gray[NSTG] ? '0 : hquo[NSTG];
  assign saturation = gray[NSTG] ? '0 : squo[NSTG];
  assign value      = val[NSTG];

endmodule

@@ hdl/rgb_to_hsv_convert_unit.sv @@
// ---------------------------------------------------------------------------
// rgb_to_hsv_convert_unit - RGB to HSV pixel converter
//
// Input side is a queue: drive red, green, blue and raise push; a pixel
// transfers on a clock edge with push high and full low. Result side is a
// queue too: while empty is low, hue, saturation and value show the oldest
// result, and it transfers on an edge with pop high.
// Throughput is one pixel per clock while pop keeps results moving. From
// input transfer to empty going low, a pixel passes the classify register,
// the queue, the load stage and the divider pipeline, which retires one
// quotient bit per stage for hue and saturation alike.
// A classify stage feeds a short queue, which feeds the divider pipeline;
// when pop is held low the pipeline fills, then the queue, and then full
// rises, with no pixel lost.
// Synchronous reset empties every stage and the queue; no results remain.
// Gray pixels (zero range) give hue and saturation of zero.
// ---------------------------------------------------------------------------
module rgb_to_hsv_convert_unit #(
  parameter int COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_BITS       = rhc_pkg::HUE_BITS_DEF,
  parameter int FIFO_DEPTH     = rhc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [COMPONENT_BITS-1:0]    red,
  input  logic [COMPONENT_BITS-1:0]    green,
  input  logic [COMPONENT_BITS-1:0]    blue,
  output logic                         empty,
  input  logic                         pop,
  output logic [HUE_BITS-1:0]          hue,
  output logic [rhc_pkg::SAT_BITS-1:0] saturation,
  output logic [COMPONENT_BITS-1:0]    value
);
  import rhc_pkg::*;

  localparam int CB     = COMPONENT_BITS;
  localparam int ITEM_W = 3 * CB + 4;

  logic              f_valid;
  logic              f_ready;
  logic [CB-1:0]     f_value;
  logic [CB-1:0]     f_range;
  logic [CB+2:0]     f_num;
  logic              f_gray;
  logic              q_full;
  logic              q_empty;
  logic [ITEM_W-1:0] q_rd_data;
  logic              b_ready;
  logic              b_valid;

  // classify incoming pixels
  rhc_front #(
    .CB (CB)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_value (f_value),
    .out_range (f_range),
    .out_num   (f_num),
    .out_gray  (f_gray)
  );

  assign f_ready = !q_full;

  // decouple classifier from dividers
  rhc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_valid),
    .wr_data ({f_gray, f_num, f_range, f_value}),
    .full    (q_full),
    .rd_en   (b_ready),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // divide for hue and saturation
  rhc_back #(
    .CB (CB),
    .HB (HUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_ready   (b_ready),
    .in_value   (q_rd_data[CB-1:0]),
    .in_range   (q_rd_data[2*CB-1:CB]),
    .in_num     (q_rd_data[3*CB+2:2*CB]),
    .in_gray    (q_rd_data[3*CB+3]),
    .out_valid  (b_valid),
    .out_ready  (pop),
    .hue        (hue),
    .saturation (saturation),
    .value      (value)
  );

  assign empty = !b_valid;

endmodule
